// ===== hw/rtl/ketr_pkg.sv =====
// ketr_pkg: shared types and constants for the key edge trigger / auto-repeat block
// depends on nothing; imported by key_edge_trigger_repeat and the testbench
`default_nettype none

package ketr_pkg;

    localparam int unsigned MODIFIER_KEYS = 11;
    localparam int unsigned KEY_COUNT     = 256;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [KEY_W:0]   KEY_LIMIT     = (KEY_W + 1)'(KEY_COUNT);
    localparam logic [KEY_W-1:0] MOD_LIMIT     = KEY_W'(MODIFIER_KEYS);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(300);

    typedef enum logic [1:0] {
        CODE_NO     = 2'd0,
        CODE_YES    = 2'd1,
        CODE_STILL  = 2'd2,
        CODE_REPEAT = 2'd3
    } t_code;

    typedef enum logic [2:0] {
        TRACK_NONE = 3'b001,
        TRACK_HELD = 3'b010,
        TRACK_SUPP = 3'b100
    } t_track;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_RESET = 1'b1
    } t_op;

    typedef enum logic {
        REG_EDGE_MODE    = 1'b0,
        REG_REPEAT_DELAY = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/key_edge_trigger_repeat.sv =====
// key_edge_trigger_repeat: typematic filter for key queries, level or edge with auto-repeat
// depends on ketr_pkg (types, key limits, result codes)
//
// One item enters an input register, is evaluated against the tracking state in a single
// combinational pass and lands in a result register, with the tracking state updated in the
// same cycle. Throughput is one item per clock unless the result side stalls. Each of the
// two registers holds one item, so a new item is still taken while a finished result waits
// downstream. No clearing pass is needed after reset. Configuration registers are written
// through a plain write port; the user must do so only while idle, unchecked by the block.
`default_nettype none

module key_edge_trigger_repeat (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire ketr_pkg::t_reg_idx              i_cfg_index,
    input  wire logic [ketr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_op,
    input  wire logic [ketr_pkg::KEY_W-1:0]      i_key_index,
    input  wire logic                            i_key_level,
    input  wire logic                            i_any_modifier,
    input  wire logic [ketr_pkg::TIME_W-1:0]     i_now_ms,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output ketr_pkg::t_code                      o_press_code,
    output logic                                 o_pressed
);
    import ketr_pkg::*;

    logic               r_edge_mode;
    logic [DELAY_W-1:0] r_repeat_delay;

    logic [KEY_W-1:0]  r_track_key;
    logic [KEY_W-1:0]  n_track_key;
    t_track            r_track_mode;
    t_track            n_track_mode;
    logic [TIME_W-1:0] r_press_time;
    logic [TIME_W-1:0] n_press_time;
    logic              r_mod_snap;
    logic              n_mod_snap;

    logic              r_s1_valid;
    logic              r_s1_op;
    logic [KEY_W-1:0]  r_s1_key;
    logic              r_s1_level;
    logic              r_s1_mods;
    logic [TIME_W-1:0] r_s1_now;

    t_code             n_code;
    logic              n_pressed;

    logic              out_free;
    logic              advance;
    logic              in_take;
    logic              same_key;
    logic              is_mod;
    logic              key_out_of_range;
    logic [TIME_W-1:0] elapsed;
    logic              delay_pending;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign same_key         = (r_s1_key == r_track_key);
    assign is_mod           = (r_s1_key < MOD_LIMIT);
    assign key_out_of_range = ({1'b0, r_s1_key} >= KEY_LIMIT);
    assign elapsed          = r_s1_now - r_press_time;
    assign delay_pending    = (elapsed < {{(TIME_W-DELAY_W){1'b0}}, r_repeat_delay});

    always_comb begin
        n_track_key  = r_track_key;
        n_track_mode = r_track_mode;
        n_press_time = r_press_time;
        n_mod_snap   = r_mod_snap;
        n_code       = CODE_NO;
        if (r_s1_op == OP_RESET) begin
            n_track_mode = TRACK_NONE;
            n_press_time = '0;
        end else if (key_out_of_range) begin
            n_code = CODE_NO;
        end else if (!r_edge_mode) begin
            n_code = r_s1_level ? CODE_YES : CODE_NO;
        end else if (!r_s1_level) begin
            if (r_track_mode == TRACK_HELD && same_key) begin
                n_track_mode = TRACK_NONE;
                n_press_time = '0;
            end
        end else begin
            unique case (r_track_mode)
                TRACK_HELD: begin
                    if (same_key) begin
                        if (r_mod_snap == r_s1_mods) begin
                            if (delay_pending) begin
                                n_code = CODE_STILL;
                            end else begin
                                n_press_time = r_s1_now;
                                n_code       = CODE_REPEAT;
                            end
                        end else begin
                            n_press_time = '0;
                            n_track_mode = TRACK_SUPP;
                        end
                    end
                end
                TRACK_SUPP: begin
                    if (same_key) begin
                        n_code = CODE_NO;
                    end
                end
                default: begin
                end
            endcase
            if (!((r_track_mode == TRACK_HELD || r_track_mode == TRACK_SUPP) && same_key)) begin
                n_code = CODE_YES;
                if (is_mod) begin
                    n_track_mode = TRACK_NONE;
                    n_press_time = '0;
                end else begin
                    n_track_key  = r_s1_key;
                    n_track_mode = TRACK_HELD;
                    n_press_time = r_s1_now;
                    n_mod_snap   = r_s1_mods;
                end
            end
        end
        if (!r_edge_mode || is_mod) begin
            n_pressed = (n_code != CODE_NO);
        end else begin
            n_pressed = (n_code == CODE_YES) || (n_code == CODE_REPEAT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode    <= 1'b0;
            r_repeat_delay <= DELAY_RESET;
            r_track_key    <= '0;
            r_track_mode   <= TRACK_NONE;
            r_press_time   <= '0;
            r_mod_snap     <= 1'b0;
            r_s1_valid     <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_EDGE_MODE:    r_edge_mode    <= i_cfg_data[0];
                    REG_REPEAT_DELAY: r_repeat_delay <= i_cfg_data[DELAY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (advance) begin
                r_track_key  <= n_track_key;
                r_track_mode <= n_track_mode;
                r_press_time <= n_press_time;
                r_mod_snap   <= n_mod_snap;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op    <= i_op;
            r_s1_key   <= i_key_index;
            r_s1_level <= i_key_level;
            r_s1_mods  <= i_any_modifier;
            r_s1_now   <= i_now_ms;
        end
        if (advance) begin
            o_press_code <= n_code;
            o_pressed    <= n_pressed;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid))
        else $error("input stalled while a stage is free");

    a_reset_clears_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s1_op == OP_RESET) |=> (r_track_mode == TRACK_NONE && r_press_time == '0))
        else $error("tracking not cleared by a reset item");

    a_no_modifier_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_track_mode == TRACK_HELD) |-> (r_track_key >= MOD_LIMIT))
        else $error("modifier key is being tracked");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for key_edge_trigger_repeat: level and edge mode queries with auto-repeat
// depends on ketr_pkg and the key_edge_trigger_repeat rtl; predicts every result and checks it
`timescale 1ns / 1ps

module testbench;
    import ketr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic              level;
        logic              mods;
        logic [TIME_W-1:0] now;
    } t_key_item;

    typedef struct packed {
        t_code code;
        logic  pressed;
    } t_press_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_reg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [KEY_W-1:0]      i_key_index;
    logic                  i_key_level;
    logic                  i_any_modifier;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_code                 o_press_code;
    logic                  o_pressed;

    // predictor state and configuration
    logic                  cfg_edge_mode;
    logic [DELAY_W-1:0]    cfg_repeat_delay;
    logic [KEY_W-1:0]      trk_key;
    t_track                trk_mode;
    logic [TIME_W-1:0]     trk_time;
    logic                  trk_mods;

    t_press_result         press_expect_q[$];
    int unsigned           mismatch_count;
    int unsigned           cycle_count;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           out_hold_left;

    logic [KEY_W-1:0]      sess_key;
    logic                  sess_mods;
    logic [TIME_W-1:0]     sess_now;

    key_edge_trigger_repeat DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_key_index    (i_key_index),
        .i_key_level    (i_key_level),
        .i_any_modifier (i_any_modifier),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_press_code   (o_press_code),
        .o_pressed      (o_pressed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_press_result typematic_predict(input t_key_item ki);
        t_press_result     r;
        logic              same;
        logic [TIME_W-1:0] elapsed;
        r.code  = CODE_NO;
        same    = (ki.key == trk_key);
        elapsed = ki.now - trk_time;
        if (ki.op == OP_RESET) begin
            trk_mode = TRACK_NONE;
            trk_time = '0;
        end else if ({1'b0, ki.key} >= KEY_LIMIT) begin
            r.code = CODE_NO;
        end else if (!cfg_edge_mode) begin
            r.code = ki.level ? CODE_YES : CODE_NO;
        end else if (!ki.level) begin
            if (trk_mode == TRACK_HELD && same) begin
                trk_mode = TRACK_NONE;
                trk_time = '0;
            end
        end else if (trk_mode == TRACK_HELD && same) begin
            if (trk_mods != ki.mods) begin
                trk_time = '0;
                trk_mode = TRACK_SUPP;
            end else if (elapsed < {{(TIME_W-DELAY_W){1'b0}}, cfg_repeat_delay}) begin
                r.code = CODE_STILL;
            end else begin
                trk_time = ki.now;
                r.code   = CODE_REPEAT;
            end
        end else if (trk_mode == TRACK_SUPP && same) begin
            r.code = CODE_NO;
        end else if (ki.key < MOD_LIMIT) begin
            trk_mode = TRACK_NONE;
            trk_time = '0;
            r.code   = CODE_YES;
        end else begin
            trk_key  = ki.key;
            trk_mode = TRACK_HELD;
            trk_time = ki.now;
            trk_mods = ki.mods;
            r.code   = CODE_YES;
        end
        if (!cfg_edge_mode || ki.key < MOD_LIMIT)
            r.pressed = (r.code != CODE_NO);
        else
            r.pressed = (r.code == CODE_YES || r.code == CODE_REPEAT);
        return r;
    endfunction

    // predicts on every accepted item, checks every accepted result
    always @(posedge i_clk) begin : result_monitor
        t_press_result want;
        t_key_item     seen;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (press_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result at cycle %0d: code %0d pressed %0b",
                                 cycle_count, o_press_code, o_pressed);
                end else begin
                    want = press_expect_q.pop_front();
                    if (o_press_code !== want.code || o_pressed !== want.pressed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("cycle %0d: code exp %0d got %0d, pressed exp %0b got %0b",
                                     cycle_count, want.code, o_press_code, want.pressed, o_pressed);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EDGE_MODE:    cfg_edge_mode    = i_cfg_data[0];
                    REG_REPEAT_DELAY: cfg_repeat_delay = i_cfg_data[DELAY_W-1:0];
                endcase
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                seen.op    = t_op'(i_op);
                seen.key   = i_key_index;
                seen.level = i_key_level;
                seen.mods  = i_any_modifier;
                seen.now   = i_now_ms;
                press_expect_q.push_back(typematic_predict(seen));
            end
        end
    end

    // result side stall, with an optional long hold
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold_left > 0) begin
                out_hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(input t_op op, input logic [KEY_W-1:0] key, input logic level,
                             input logic mods, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_key_index    <= key;
        i_key_level    <= level;
        i_any_modifier <= mods;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (press_expect_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_level_mode();
        write_reg(REG_EDGE_MODE, 16'd0);
        send_item(OP_QUERY, 8'd0, 1'b1, 1'b0, 32'd0);
        send_item(OP_QUERY, 8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 8'd128, 1'b0, 1'b0, 32'd77);
        send_item(OP_RESET, 8'd10, 1'b1, 1'b1, 32'd5);
    endtask

    task automatic test_edge_sequence();
        write_reg(REG_EDGE_MODE, 16'd1);
        write_reg(REG_REPEAT_DELAY, 16'd300);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1000);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1100);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1300);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1599);
        send_item(OP_QUERY, 8'd40, 1'b0, 1'b0, 32'd1650);
        // modifier change while held, then the suppressed key released and pressed again
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b1, 32'd1700);
        send_item(OP_QUERY, 8'd20, 1'b0, 1'b1, 32'd1710);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1720);
        send_item(OP_QUERY, 8'd10, 1'b1, 1'b1, 32'd1730);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1740);
        send_item(OP_QUERY, 8'd11, 1'b1, 1'b0, 32'd1750);
        send_item(OP_QUERY, 8'd20, 1'b1, 1'b0, 32'd1760);
        send_item(OP_QUERY, 8'd20, 1'b0, 1'b0, 32'd1770);
        // repeat timing across the 32-bit wrap
        send_item(OP_QUERY, 8'd255, 1'b1, 1'b1, 32'hFFFF_FF00);
        send_item(OP_QUERY, 8'd255, 1'b1, 1'b1, 32'h0000_0010);
        send_item(OP_QUERY, 8'd255, 1'b1, 1'b1, 32'h0000_002C);
        send_item(OP_RESET, 8'd255, 1'b1, 1'b1, 32'h0000_0030);
        send_item(OP_QUERY, 8'd255, 1'b1, 1'b1, 32'h0000_0030);
        send_item(OP_QUERY, 8'd0, 1'b0, 1'b0, 32'd0);
    endtask

    task automatic test_delay_extremes();
        write_reg(REG_REPEAT_DELAY, 16'd0);
        send_item(OP_QUERY, 8'd50, 1'b1, 1'b0, 32'd5);
        send_item(OP_QUERY, 8'd50, 1'b1, 1'b0, 32'd5);
        write_reg(REG_REPEAT_DELAY, 16'hFFFF);
        send_item(OP_QUERY, 8'd60, 1'b1, 1'b0, 32'd100);
        send_item(OP_QUERY, 8'd60, 1'b1, 1'b0, 32'd100 + 32'd65534);
        send_item(OP_QUERY, 8'd60, 1'b1, 1'b0, 32'd100 + 32'd65535);
    endtask

    // mostly held-key sessions with advancing time, some noise, resets and other keys
    task automatic test_random_traffic(input int unsigned count);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_item(t_op'($urandom_range(1)), KEY_W'($urandom), 1'($urandom),
                          1'($urandom), $urandom);
            end else if (roll < 12) begin
                send_item(OP_RESET, sess_key, 1'b1, sess_mods, sess_now);
            end else begin
                if ($urandom_range(11) == 0)
                    sess_key = ($urandom_range(3) == 0) ?
                               KEY_W'($urandom_range(MODIFIER_KEYS - 1)) :
                               KEY_W'(MODIFIER_KEYS + $urandom_range(4));
                if ($urandom_range(24) == 0)
                    sess_mods = ~sess_mods;
                sess_now += $urandom_range({16'd0, cfg_repeat_delay} / 3 + 8);
                if (roll < 25)
                    send_item(OP_QUERY, KEY_W'($urandom), 1'($urandom), sess_mods, sess_now);
                else
                    send_item(OP_QUERY, sess_key, ($urandom_range(11) != 0), sess_mods, sess_now);
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        out_hold_left  = 200;
        test_random_traffic(30);
        wait_results_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_EDGE_MODE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_op           = OP_QUERY;
        i_key_index    = '0;
        i_key_level    = 1'b0;
        i_any_modifier = 1'b0;
        i_now_ms       = '0;
        cfg_edge_mode    = 1'b0;
        cfg_repeat_delay = DELAY_RESET;
        trk_key          = '0;
        trk_mode         = TRACK_NONE;
        trk_time         = '0;
        trk_mods         = 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        out_hold_left    = 0;
        sess_key         = 8'd12;
        sess_mods        = 1'b0;
        sess_now         = 32'hFFFF_F000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_level_mode();
        test_edge_sequence();
        test_delay_extremes();

        send_idle_pct  = 19;
        recv_stall_pct = 75;
        write_reg(REG_REPEAT_DELAY, 16'd300);
        test_random_traffic(300);

        send_idle_pct  = 75;
        recv_stall_pct = 19;
        write_reg(REG_REPEAT_DELAY, 16'd37);
        test_random_traffic(300);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_REPEAT_DELAY, 16'hFFFF);
        test_random_traffic(100);
        write_reg(REG_REPEAT_DELAY, 16'd0);
        test_random_traffic(80);
        write_reg(REG_EDGE_MODE, 16'd0);
        test_random_traffic(80);

        write_reg(REG_EDGE_MODE, 16'd1);
        write_reg(REG_REPEAT_DELAY, 16'd120);
        test_backpressure();

        wait_results_drained();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
